@@ hw/rtl/wmh_pkg.sv @@
// shared types, constants and hash functions for the window minimizer hash block
package wmh_pkg;

  localparam int unsigned MAX_KMER_LENGTH = 31;
  localparam int unsigned Q_W             = 5;
  localparam int unsigned WORD_W          = 2 * MAX_KMER_LENGTH;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [Q_W-1:0]    qlen_t;

  // one classified base on its way to the hash unit
  typedef struct packed {
    word_t key;
    logic  hash_en;
    logic  last;
  } wmh_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } wmh_queue_status_t;

  // zero means one, above the maximum means the maximum
  function automatic qlen_t eff_q(input qlen_t k);
    qlen_t q;
    q = k;
    if (q == '0) begin
      q = qlen_t'(1);
    end
    if (q > qlen_t'(MAX_KMER_LENGTH)) begin
      q = qlen_t'(MAX_KMER_LENGTH);
    end
    return q;
  endfunction

  // 2q low bits set
  function automatic word_t kmer_mask(input qlen_t q);
    word_t all_ones;
    logic [Q_W:0] drop;
    all_ones = '1;
    drop = (Q_W+1)'(WORD_W) - {q, 1'b0};
    return all_ones >> drop;
  endfunction

  function automatic word_t mix_s1(input word_t key, input word_t mask);
    word_t k;
    k = (~key + (key << 21)) & mask;
    return k ^ (k >> 24);
  endfunction

  function automatic word_t mix_s2(input word_t key, input word_t mask);
    word_t k;
    k = (key + (key << 3) + (key << 8)) & mask;
    return k ^ (k >> 14);
  endfunction

  function automatic word_t mix_s3(input word_t key, input word_t mask);
    word_t k;
    k = (key + (key << 2) + (key << 4)) & mask;
    return k ^ (k >> 28);
  endfunction

  function automatic word_t mix_s4(input word_t key, input word_t mask);
    return (key + (key << 31)) & mask;
  endfunction

  function automatic word_t mix_full(input word_t key, input word_t mask);
    return mix_s4(mix_s3(mix_s2(mix_s1(key, mask), mask), mask), mask);
  endfunction

endpackage

@@ hw/rtl/wmh_in_if.sv @@
// input channel: one nucleotide per transfer
interface wmh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] base;
  logic       last_base;

  modport source (output valid, output base, output last_base, input ready);
  modport sink   (input valid, input base, input last_base, output ready);
endinterface

@@ hw/rtl/wmh_out_if.sv @@
// output channel: one window minimum per transfer
interface wmh_out_if;
  logic        valid;
  logic        ready;
  logic [61:0] min_hash;
  logic        had_kmer;

  modport source (output valid, output min_hash, output had_kmer, input ready);
  modport sink   (input valid, input min_hash, input had_kmer, output ready);
endinterface

@@ hw/rtl/wmh_front.sv @@
// front end: k-mer shift register, base counter and hash-enable decision
module wmh_front
  import wmh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  qlen_t             q,
  input  word_t             mask,
  input  wmh_queue_status_t qstat,
  wmh_in_if.sink            in_ch,
  output logic              push,
  output wmh_item_t         push_item
);

  word_t kmer_shift;
  word_t kmer_shift_next;
  qlen_t bases_seen;
  qlen_t seen_clamped;
  qlen_t bases_seen_next;

  assign in_ch.ready = !qstat.full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    kmer_shift_next = ((kmer_shift << 2) | word_t'(in_ch.base)) & mask;
    seen_clamped    = (bases_seen > q) ? q : bases_seen;
    bases_seen_next = (seen_clamped < q) ? seen_clamped + qlen_t'(1) : seen_clamped;
    push_item.hash_en = (bases_seen_next == q);
    push_item.last    = in_ch.last_base;
    // short windows hash the all-zero k-mer
    push_item.key     = push_item.hash_en ? kmer_shift_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_shift <= '0;
      bases_seen <= '0;
    end else if (push) begin
      if (in_ch.last_base) begin
        kmer_shift <= '0;
        bases_seen <= '0;
      end else begin
        kmer_shift <= kmer_shift_next;
        bases_seen <= bases_seen_next;
      end
    end
  end

endmodule

@@ hw/rtl/wmh_queue.sv @@
// short fifo between front and back
module wmh_queue
  import wmh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wmh_item_t         push_item,
  input  logic              pop,
  output wmh_item_t         head,
  output wmh_queue_status_t qstat
);

  wmh_item_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign head        = slots[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/wmh_back.sv @@
// back end: four-stage hash pipeline, running minimum and output register
module wmh_back
  import wmh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  word_t             mask,
  input  wmh_item_t         head,
  input  wmh_queue_status_t qstat,
  output logic              pop,
  wmh_out_if.source         out_ch
);

  logic      advance;
  logic      v1, v2, v3, v4;
  wmh_item_t p1, p2, p3, p4;
  word_t     best_hash;
  logic      best_valid;
  logic      better;
  logic      out_valid;
  word_t     out_hash;
  logic      out_had;
  word_t     res_hash;
  logic      res_had;

  // whole pipe moves together whenever the output register can take a result
  assign advance = !out_valid || out_ch.ready;
  assign pop     = advance && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= !qstat.empty;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1.key     <= mix_s1(head.key, mask);
      p1.hash_en <= head.hash_en;
      p1.last    <= head.last;
      p2.key     <= mix_s2(p1.key, mask);
      p2.hash_en <= p1.hash_en;
      p2.last    <= p1.last;
      p3.key     <= mix_s3(p2.key, mask);
      p3.hash_en <= p2.hash_en;
      p3.last    <= p2.last;
      p4.key     <= mix_s4(p3.key, mask);
      p4.hash_en <= p3.hash_en;
      p4.last    <= p3.last;
    end
  end

  always_comb begin
    better   = p4.hash_en && (!best_valid || (p4.key < best_hash));
    res_had  = better || best_valid;
    res_hash = better ? p4.key : (best_valid ? (best_hash & mask) : p4.key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_hash  <= '0;
    end else if (advance && v4) begin
      if (p4.last) begin
        best_valid <= 1'b0;
        best_hash  <= '0;
      end else if (better) begin
        best_valid <= 1'b1;
        best_hash  <= p4.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v4 && p4.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v4 && p4.last) begin
      out_hash <= res_hash;
      out_had  <= res_had;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.min_hash = out_hash;
  assign out_ch.had_kmer = out_had;

endmodule

@@ hw/rtl/window_minimizer_hash_unit.sv @@
// top level of the streaming dna minimizer with invertible 64-bit style hash
//
// channel  | dir | payload                        | transfer when
// ---------+-----+--------------------------------+-------------------------
// in_ch    | in  | base[1:0], last_base           | in_ch.valid & in_ch.ready
// out_ch   | out | min_hash[61:0], had_kmer       | out_ch.valid & out_ch.ready
// cfg      | in  | cfg_wr_data[4:0] (kmer_length) | cfg_wr_en
//
// one base per cycle while the output is taken; a result is registered in the
// queue, four hash stages and the output register after its last base transfers
// latency is set by the queue, the hash pipeline and the output register;
// throughput is one base per cycle while the output is taken
// synchronous reset clears the k-mer, the base count, the window minimum, the
// queue and pipe valids; kmer_length resets to 15
// a stalled output holds the whole back pipe; the 4-entry queue keeps the front
// taking bases until it fills
module window_minimizer_hash_unit
  import wmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  wmh_in_if.sink     in_ch,
  wmh_out_if.source  out_ch
);

  // configuration register and the derived k-mer size and mask
  qlen_t kmer_length;
  qlen_t q;
  word_t mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= qlen_t'(15);
    end else if (cfg_wr_en) begin
      kmer_length <= cfg_wr_data;
    end
  end

  assign q    = eff_q(kmer_length);
  assign mask = kmer_mask(q);

  // front to queue
  logic              push;
  wmh_item_t         push_item;
  // queue to back
  logic              pop;
  wmh_item_t         head;
  wmh_queue_status_t qstat;

  // classifies each base: shift in, count, decide whether a full k-mer exists
  wmh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .q         (q),
    .mask      (mask),
    .qstat     (qstat),
    .in_ch     (in_ch),
    .push      (push),
    .push_item (push_item)
  );

  // decouples the base stream from output stalls
  wmh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // hashes, keeps the strict minimum and emits one result per window
  wmh_back u_back (
    .clk    (clk),
    .rst    (rst),
    .mask   (mask),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // queue can never look both full and empty
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  // no result may leave in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("output valid right after reset");

  // a window without a complete k-mer reports the hash of the zero k-mer
  a_empty_window: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.had_kmer) |-> (out_ch.min_hash == mix_full('0, mask)))
    else $error("short window result is not the zero k-mer hash");

  // nothing is pulled from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule
